>>> hw/rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    // Command opcodes as they arrive in the input word.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_WAIT  = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Reset value of the acknowledge wait limit.
    localparam logic [7:0] ACK_WAIT_RESET = 8'd200;

    // Last phase of a byte write: eight bits of three phases, then SCL low.
    localparam logic [4:0] WRITE_LAST_PHASE = 5'd24;
    // Last phase of a byte read: eight bits of two phases.
    localparam logic [4:0] READ_LAST_PHASE  = 5'd15;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_is_input;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_timeout;
    } i2cm_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cm_core.sv
`default_nettype none

module i2cm_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire i2cm_pkg::i2cm_in_t word,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_wdata,
    output i2cm_pkg::i2cm_out_t     result
);
    import i2cm_pkg::*;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_STOP,
        CMD_ACK,
        CMD_WAIT,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    cmd_t       cmd_reg, cmd_next;
    logic [4:0] phase_reg, phase_next;
    logic [1:0] sub_reg, sub_next;
    logic [7:0] tx_reg, tx_next;
    logic [7:0] rx_reg, rx_next;
    logic [7:0] wait_reg, wait_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       rd_reg, rd_next;
    logic       timeout_reg, timeout_next;
    logic [7:0] limit_reg;
    logic       busy;
    logic       fin;
    logic       hold;

    // One tick: take a new command if idle, then run one phase of the active one.
    always_comb
    begin
        cmd_next     = cmd_reg;
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        wait_next    = wait_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rd_next      = rd_reg;
        timeout_next = timeout_reg;
        fin          = 1'b0;
        hold         = 1'b0;

        if (cmd_reg == CMD_IDLE && word.cmd_valid)
        begin
            phase_next = '0;
            sub_next   = '0;
            unique case (word.opcode)
                OP_START: cmd_next = CMD_START;
                OP_STOP:  cmd_next = CMD_STOP;
                OP_ACK:
                begin
                    cmd_next = CMD_ACK;
                    tx_next  = {7'd0, word.ack_level};
                end
                OP_WAIT:
                begin
                    cmd_next     = CMD_WAIT;
                    wait_next    = '0;
                    timeout_next = 1'b0;
                    rd_next      = 1'b1;
                end
                OP_WRITE:
                begin
                    cmd_next = CMD_WRITE;
                    tx_next  = word.tx_byte;
                end
                OP_READ:
                begin
                    cmd_next = CMD_READ;
                    rx_next  = '0;
                    rd_next  = 1'b1;
                end
                default:
                begin
                    // Unused opcodes leave the sequencer idle.
                    phase_next = phase_reg;
                    sub_next   = sub_reg;
                end
            endcase
        end

        busy = (cmd_next != CMD_IDLE);

        unique case (cmd_next)
            CMD_START:
            begin
                if (phase_next == 5'd0)
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                else if (phase_next == 5'd1)
                    sda_next = 1'b0;
                else
                begin
                    scl_next = 1'b0;
                    fin      = 1'b1;
                end
            end
            CMD_STOP:
            begin
                if (phase_next == 5'd0)
                    sda_next = 1'b0;
                else if (phase_next == 5'd1)
                    scl_next = 1'b1;
                else
                begin
                    sda_next = 1'b1;
                    fin      = 1'b1;
                end
            end
            CMD_ACK:
            begin
                if (phase_next == 5'd0)
                    sda_next = tx_next[0];
                else if (phase_next == 5'd1)
                    scl_next = 1'b1;
                else
                begin
                    scl_next = 1'b0;
                    fin      = 1'b1;
                end
            end
            CMD_WAIT:
            begin
                if (phase_next == 5'd0)
                begin
                    if (!word.sda_in)
                        scl_next = 1'b1;
                    else if (wait_next >= limit_reg)
                    begin
                        timeout_next = 1'b1;
                        rd_next      = 1'b0;
                        fin          = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_next + 8'd1;
                        hold      = 1'b1;
                    end
                end
                else
                begin
                    scl_next = 1'b0;
                    rd_next  = 1'b0;
                    fin      = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (phase_next >= WRITE_LAST_PHASE)
                begin
                    scl_next = 1'b0;
                    fin      = 1'b1;
                end
                else
                begin
                    unique case (sub_next)
                        2'd0: scl_next = 1'b0;
                        2'd1: sda_next = tx_next[7];
                        default:
                        begin
                            scl_next = 1'b1;
                            tx_next  = {tx_next[6:0], 1'b0};
                        end
                    endcase
                    sub_next = (sub_next == 2'd2) ? 2'd0 : sub_next + 2'd1;
                end
            end
            CMD_READ:
            begin
                if (!phase_next[0])
                    scl_next = 1'b1;
                else
                begin
                    rx_next  = {rx_next[6:0], word.sda_in};
                    scl_next = 1'b0;
                    if (phase_next >= READ_LAST_PHASE)
                    begin
                        rd_next = 1'b0;
                        fin     = 1'b1;
                    end
                end
            end
            default:
            begin
                hold = 1'b1;
            end
        endcase

        if (fin)
        begin
            cmd_next   = CMD_IDLE;
            phase_next = '0;
            sub_next   = '0;
        end
        else if (!hold)
            phase_next = phase_next + 5'd1;
    end

    always_comb
    begin
        result.scl_level    = scl_next;
        result.sda_level    = rd_next ? 1'b1 : sda_next;
        result.sda_is_input = rd_next;
        result.busy_res     = busy;
        result.done_res     = fin;
        result.rx_byte      = rx_next;
        result.ack_timeout  = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= CMD_IDLE;
            phase_reg   <= '0;
            sub_reg     <= '0;
            tx_reg      <= '0;
            rx_reg      <= '0;
            wait_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rd_reg      <= 1'b0;
            timeout_reg <= 1'b0;
        end
        else if (en)
        begin
            cmd_reg     <= cmd_next;
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            wait_reg    <= wait_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            rd_reg      <= rd_next;
            timeout_reg <= timeout_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= ACK_WAIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

`ifndef SYNTHESIS
    // The phase counter is parked at zero whenever no command runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_IDLE |-> phase_reg == 5'd0 && sub_reg == 2'd0)
        else $error("phase counter not cleared while idle");

    // A write never runs past its final phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_WRITE |-> phase_reg <= WRITE_LAST_PHASE)
        else $error("write phase out of range");

    // SDA is only released for reading during wait ack or read.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg |-> cmd_reg == CMD_WAIT || cmd_reg == CMD_READ)
        else $error("SDA released outside a read or wait");

    // A completing tick always leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        en && fin |=> cmd_reg == CMD_IDLE)
        else $error("command still active after done");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/i2c_bit_level_master_top.sv
`default_nettype none

// Line-level I2C master. Every input word is one bit-time tick: it carries the
// sampled SDA level and, when cmd_valid is set, a command (start, stop, send
// ack or nack, wait for ack, write a byte MSB first, read a byte MSB first).
// Every accepted word yields exactly one output word with the SCL level, the
// SDA level (1 when released), the read-mode flag, busy and done, the receive
// shift register and the ack-timeout flag. Commands offered while a command is
// running, and opcodes 6 and 7, are ignored. The block takes one word per
// clock cycle when the output side does not stall; a word passes an input
// register and the sequencer logic into the output register, from which its
// result is taken. Output stall backs up through both registers to in_stall.
// The acknowledge wait limit (reset 200) is written through cfg_we and
// cfg_wdata and must only be changed while no word is in flight.
module i2c_bit_level_master_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire i2cm_pkg::i2cm_in_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output i2cm_pkg::i2cm_out_t      out_word,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata
);
    import i2cm_pkg::*;

    logic      in_valid_reg;
    i2cm_in_t  in_word_reg;
    logic      out_valid_reg;
    i2cm_out_t out_word_reg;
    i2cm_out_t step_result;
    logic      move;

    // A word moves from the input register into the output register when the
    // output register is empty or is being taken in this cycle.
    assign move     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !move;

    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (move),
        .word      (in_word_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= move;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
        if (move)
            out_word_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire
